@@ rtl/flvd_pkg.sv @@
// ----------------------------------------------------------------------------
// flvd_pkg
// Shared types and constants for the tag deframer.
// ----------------------------------------------------------------------------
package flvd_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned SIZE_W     = 24;
   localparam int unsigned LEN_W      = 17;
   localparam int unsigned CMP_W      = 25;

   localparam logic [BYTE_W-1:0] SIG_F       = 8'h46;
   localparam logic [BYTE_W-1:0] SIG_L       = 8'h4C;
   localparam logic [BYTE_W-1:0] SIG_V       = 8'h56;
   localparam logic [BYTE_W-1:0] SIG_VERSION = 8'h01;

   localparam int unsigned HEADER_LEN  = 13;
   localparam int unsigned MIN_SIZE    = 11;
   localparam int unsigned LEN_EXTRA   = 15;
   localparam int unsigned LAST_OFFSET = 14;

   // tag byte positions
   localparam int unsigned POS_TYPE      = 0;
   localparam int unsigned POS_SIZE_LO   = 3;
   localparam int unsigned POS_STAMP_LO  = 6;
   localparam int unsigned POS_FLAG      = 11;
   localparam int unsigned POS_FIRST_END = 12;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_HEADER = 2'd1,
      ERR_SMALL  = 2'd2,
      ERR_LARGE  = 2'd3
   } err_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              packet_start;
      logic              packet_end;
      logic [BYTE_W-1:0] tag_kind;
      logic [BYTE_W-1:0] frame_flag;
      logic [SIZE_W-1:0] stamp_ms;
      logic [LEN_W-1:0]  packet_length;
      err_type           error_code;
   } rsp_type;

endpackage

@@ rtl/flvd_in_stage.sv @@
// ----------------------------------------------------------------------------
// flvd_in_stage
// Input register for one stream byte; releases it when the result side
// has room.
// ----------------------------------------------------------------------------
module flvd_in_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [flvd_pkg::BYTE_W-1:0] req_stream_byte,
   input  logic                       out_free,
   output logic                       step,
   output logic [flvd_pkg::BYTE_W-1:0] step_byte
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [flvd_pkg::BYTE_W-1:0] byte_ff;
   logic                        accept;

   assign step      = valid_ff & out_free;
   assign req_stall = valid_ff & ~out_free;
   assign accept    = req_valid & ~req_stall;
   assign step_byte = byte_ff;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_stream_byte;
      end
   end

endmodule

@@ rtl/flvd_parser.sv @@
// ----------------------------------------------------------------------------
// flvd_parser
// Header check and tag framing state; builds one result per tag byte, plus an error result on a bad header byte.
// ----------------------------------------------------------------------------
module flvd_parser #(
   parameter int unsigned BUFFER_BYTES = 65536
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [flvd_pkg::BYTE_W-1:0] step_byte,
   output logic                        has_result,
   output flvd_pkg::rsp_type           result
);

   localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + flvd_pkg::LAST_OFFSET);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_TAG    = 2'd1,
      PH_HALT   = 2'd2
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [flvd_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [flvd_pkg::SIZE_W-1:0] stamp_ff, stamp_in;
   logic [flvd_pkg::BYTE_W-1:0] kind_ff, kind_in;
   logic [flvd_pkg::BYTE_W-1:0] flag_ff, flag_in;

   logic [flvd_pkg::SIZE_W-1:0] size_shift;
   logic [flvd_pkg::SIZE_W-1:0] stamp_shift;
   logic [CNT_W-1:0]            count_inc;
   logic [flvd_pkg::CMP_W-1:0]  pos_wide;
   logic [flvd_pkg::CMP_W-1:0]  last_pos;
   logic                        bad_sig;
   logic                        is_last;

   assign size_shift  = {size_ff[flvd_pkg::SIZE_W-flvd_pkg::BYTE_W-1:0], step_byte};
   assign stamp_shift = {stamp_ff[flvd_pkg::SIZE_W-flvd_pkg::BYTE_W-1:0], step_byte};
   assign count_inc   = count_ff + CNT_W'(1);
   assign pos_wide    = flvd_pkg::CMP_W'(count_ff);
   assign last_pos    = flvd_pkg::CMP_W'(size_ff) + flvd_pkg::CMP_W'(flvd_pkg::LAST_OFFSET);
   assign is_last     = (pos_wide >= flvd_pkg::CMP_W'(flvd_pkg::POS_FIRST_END)) &&
                        (pos_wide == last_pos);

   always_comb begin
      bad_sig = 1'b0;
      priority if (count_ff == CNT_W'(0)) begin
         bad_sig = (step_byte != flvd_pkg::SIG_F);
      end else if (count_ff == CNT_W'(1)) begin
         bad_sig = (step_byte != flvd_pkg::SIG_L);
      end else if (count_ff == CNT_W'(2)) begin
         bad_sig = (step_byte != flvd_pkg::SIG_V);
      end else if (count_ff == CNT_W'(3)) begin
         bad_sig = (step_byte != flvd_pkg::SIG_VERSION);
      end else begin
         bad_sig = 1'b0;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      size_in    = size_ff;
      stamp_in   = stamp_ff;
      kind_in    = kind_ff;
      flag_in    = flag_ff;
      has_result = 1'b0;
      result     = '0;
      result.out_byte   = step_byte;
      result.error_code = flvd_pkg::ERR_NONE;

      unique case (phase_ff)
         PH_HEADER: begin
            if (bad_sig) begin
               has_result        = 1'b1;
               result.packet_end = 1'b1;
               result.error_code = flvd_pkg::ERR_HEADER;
               phase_in          = PH_HALT;
            end else if (count_inc >= CNT_W'(flvd_pkg::HEADER_LEN)) begin
               phase_in = PH_TAG;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end
         PH_TAG: begin
            has_result = 1'b1;
            priority if (count_ff == CNT_W'(flvd_pkg::POS_TYPE)) begin
               kind_in  = step_byte;
               size_in  = '0;
               stamp_in = '0;
               flag_in  = '0;
            end else if (count_ff <= CNT_W'(flvd_pkg::POS_SIZE_LO)) begin
               size_in = size_shift;
               if (count_ff == CNT_W'(flvd_pkg::POS_SIZE_LO) &&
                   size_shift < flvd_pkg::SIZE_W'(flvd_pkg::MIN_SIZE)) begin
                  result.error_code = flvd_pkg::ERR_SMALL;
               end
            end else if (count_ff <= CNT_W'(flvd_pkg::POS_STAMP_LO)) begin
               stamp_in = stamp_shift;
            end else if (count_ff == CNT_W'(flvd_pkg::POS_FLAG)) begin
               flag_in = step_byte;
               if (flvd_pkg::CMP_W'(size_ff) >= flvd_pkg::CMP_W'(BUFFER_BYTES - 1)) begin
                  result.error_code = flvd_pkg::ERR_LARGE;
               end
            end else begin
               size_in = size_ff;
            end

            if (result.error_code != flvd_pkg::ERR_NONE) begin
               result.packet_end = 1'b1;
               phase_in          = PH_HALT;
            end else begin
               result.packet_start = (count_ff == CNT_W'(flvd_pkg::POS_TYPE));
               if (is_last) begin
                  result.packet_end    = 1'b1;
                  result.tag_kind      = kind_ff;
                  result.frame_flag    = flag_ff;
                  result.stamp_ms      = stamp_ff;
                  result.packet_length = flvd_pkg::LEN_W'(size_ff) +
                                         flvd_pkg::LEN_W'(flvd_pkg::LEN_EXTRA);
                  count_in             = '0;
               end else begin
                  count_in = count_inc;
               end
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      if (!step) begin
         has_result = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         count_ff <= '0;
         size_ff  <= '0;
         stamp_ff <= '0;
         kind_ff  <= '0;
         flag_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         size_ff  <= size_in;
         stamp_ff <= stamp_in;
         kind_ff  <= kind_in;
         flag_ff  <= flag_in;
      end
   end

endmodule

@@ rtl/flvd_out_stage.sv @@
// ----------------------------------------------------------------------------
// flvd_out_stage
// Result register; holds a response until the downstream side takes it.
// ----------------------------------------------------------------------------
module flvd_out_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  flvd_pkg::rsp_type            result,
   output logic                         out_free,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [flvd_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                         rsp_packet_start,
   output logic                         rsp_packet_end,
   output logic [flvd_pkg::BYTE_W-1:0]  rsp_tag_kind,
   output logic [flvd_pkg::BYTE_W-1:0]  rsp_frame_flag,
   output logic [flvd_pkg::SIZE_W-1:0]  rsp_stamp_ms,
   output logic [flvd_pkg::LEN_W-1:0]   rsp_packet_length,
   output logic [1:0]                   rsp_error_code
);

   logic              valid_ff;
   logic              valid_in;
   flvd_pkg::rsp_type data_ff;

   assign out_free = ~valid_ff | ~rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = data_ff.out_byte;
   assign rsp_packet_start  = data_ff.packet_start;
   assign rsp_packet_end    = data_ff.packet_end;
   assign rsp_tag_kind      = data_ff.tag_kind;
   assign rsp_frame_flag    = data_ff.frame_flag;
   assign rsp_stamp_ms      = data_ff.stamp_ms;
   assign rsp_packet_length = data_ff.packet_length;
   assign rsp_error_code    = data_ff.error_code;

endmodule

@@ rtl/flv_tag_deframer.sv @@
// ----------------------------------------------------------------------------
// flv_tag_deframer
// Path: a request is held in the input register; its result is registered in the response register.
// Throughput: one byte per cycle while the response side is not stalled, set by the parse step.
// Reset (synchronous): back to header check, counters and tag fields zeroed.
// ----------------------------------------------------------------------------
module flv_tag_deframer #(
   parameter int unsigned BUFFER_BYTES = 65536
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [flvd_pkg::BYTE_W-1:0]  req_stream_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [flvd_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                         rsp_packet_start,
   output logic                         rsp_packet_end,
   output logic [flvd_pkg::BYTE_W-1:0]  rsp_tag_kind,
   output logic [flvd_pkg::BYTE_W-1:0]  rsp_frame_flag,
   output logic [flvd_pkg::SIZE_W-1:0]  rsp_stamp_ms,
   output logic [flvd_pkg::LEN_W-1:0]   rsp_packet_length,
   output logic [1:0]                   rsp_error_code
);

   logic                        out_free;
   logic                        step;
   logic [flvd_pkg::BYTE_W-1:0] step_byte;
   logic                        has_result;
   flvd_pkg::rsp_type           result;

   flvd_in_stage u_in_stage (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .out_free        (out_free),
      .step            (step),
      .step_byte       (step_byte)
   );

   flvd_parser #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .step_byte  (step_byte),
      .has_result (has_result),
      .result     (result)
   );

   flvd_out_stage u_out_stage (
      .clock             (clock),
      .reset             (reset),
      .load              (has_result),
      .result            (result),
      .out_free          (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_packet_start  (rsp_packet_start),
      .rsp_packet_end    (rsp_packet_end),
      .rsp_tag_kind      (rsp_tag_kind),
      .rsp_frame_flag    (rsp_frame_flag),
      .rsp_stamp_ms      (rsp_stamp_ms),
      .rsp_packet_length (rsp_packet_length),
      .rsp_error_code    (rsp_error_code)
   );

endmodule
